FILE: hw/rtl/dest_pkg.sv
// ----------------------------------------------------------------------------
// dest_pkg
// Shared types and constants for the edge store with topological sort.
// ----------------------------------------------------------------------------
package dest_pkg;

  // Number of vertices held in the edge matrix.
  localparam int VERTEX_COUNT = 32;
  localparam int VIDX_W       = $clog2(VERTEX_COUNT);
  // Member list depth and widths.
  localparam int MEMBER_MAX   = 32;
  localparam int MIDX_W       = $clog2(MEMBER_MAX);
  localparam int MCNT_W       = $clog2(MEMBER_MAX + 1);
  localparam int DEG_W        = 6;

  // Command codes.
  localparam logic [2:0] CMD_ADD_EDGE   = 3'd0;
  localparam logic [2:0] CMD_REMOVE     = 3'd1;
  localparam logic [2:0] CMD_QUERY      = 3'd2;
  localparam logic [2:0] CMD_ADD_MEMBER = 3'd3;
  localparam logic [2:0] CMD_SORT       = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_CYCLE = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] from_vertex;
    logic [7:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       edge_present;
    logic [5:0] vertex;
    logic       vertex_valid;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec_single;
    logic emit_empty;
    logic sort_init;
    logic deg_step;
    logic scan_step;
    logic pick_mark;
    logic pick_emit;
    logic emit_cycle;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sort;
    logic count_zero;
    logic slot_free;
    logic idx_last;
    logic candidate;
    logic done_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/dest_datapath.sv
// ----------------------------------------------------------------------------
// dest_datapath
// Edge matrix, member list, in-degree counters and the result register.
// ----------------------------------------------------------------------------
module dest_datapath import dest_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [VERTEX_COUNT-1:0] adj_r [VERTEX_COUNT];
  logic [VIDX_W-1:0]       list_r [MEMBER_MAX];
  logic [DEG_W-1:0]        deg_r [VERTEX_COUNT];
  logic [VERTEX_COUNT-1:0] mask_r;
  logic [VERTEX_COUNT-1:0] visited_r;
  logic [MCNT_W-1:0]       count_r;
  logic [MIDX_W-1:0]       idx_r;
  logic [MIDX_W-1:0]       done_r;
  in_item_t                item_r;
  out_item_t               out_r;
  logic                    out_valid_r;

  logic              f_ok, t_ok;
  logic [VIDX_W-1:0] f_idx, t_idx, v;
  logic [VERTEX_COUNT-1:0] row_f, row_v;
  logic              edge_bit, full, dup;
  logic              slot_free;
  logic              pick_any;

  // Decode of the latched request.
  assign f_ok     = item_r.from_vertex < 8'(VERTEX_COUNT);
  assign t_ok     = item_r.to_vertex < 8'(VERTEX_COUNT);
  assign f_idx    = item_r.from_vertex[VIDX_W-1:0];
  assign t_idx    = item_r.to_vertex[VIDX_W-1:0];
  assign row_f    = adj_r[f_idx];
  assign edge_bit = row_f[t_idx];
  assign full     = count_r == MCNT_W'(MEMBER_MAX);
  assign dup      = mask_r[f_idx];
  assign v        = list_r[idx_r];
  assign row_v    = adj_r[v];
  assign slot_free = !out_valid_r || !out_stall;
  assign pick_any = cmd.pick_mark || cmd.pick_emit;

  // Status toward the controller.
  assign stat.is_sort    = item_r.command == CMD_SORT;
  assign stat.count_zero = count_r == '0;
  assign stat.slot_free  = slot_free;
  assign stat.idx_last   = MCNT_W'(idx_r) == count_r - MCNT_W'(1);
  assign stat.candidate  = !visited_r[v] && deg_r[v] == '0;
  assign stat.done_last  = MCNT_W'(done_r) == count_r - MCNT_W'(1);

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Edge matrix, membership and sort bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < VERTEX_COUNT; r++) begin
        adj_r[r] <= '0;
      end
      mask_r    <= '0;
      visited_r <= '0;
      count_r   <= '0;
      idx_r     <= '0;
      done_r    <= '0;
    end else begin
      if (cmd.exec_single) begin
        unique case (item_r.command)
          CMD_ADD_EDGE: begin
            if (f_ok && t_ok && item_r.from_vertex != item_r.to_vertex) begin
              adj_r[f_idx][t_idx] <= 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (f_ok && t_ok && edge_bit) begin
              adj_r[f_idx][t_idx] <= 1'b0;
            end
          end
          CMD_ADD_MEMBER: begin
            if (f_ok && !full && !dup) begin
              list_r[count_r[MIDX_W-1:0]] <= f_idx;
              mask_r[f_idx] <= 1'b1;
              count_r       <= count_r + MCNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.sort_init) begin
        visited_r <= '0;
        idx_r     <= '0;
        done_r    <= '0;
      end
      if (cmd.deg_step) begin
        idx_r <= stat.idx_last ? '0 : idx_r + MIDX_W'(1);
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + MIDX_W'(1);
      end
      // A pick in either pass marks the vertex and restarts the scan.
      if (pick_any) begin
        visited_r[v] <= 1'b1;
        done_r       <= done_r + MIDX_W'(1);
        idx_r        <= '0;
      end
      // The list empties after every sort.
      if (cmd.emit_empty || cmd.emit_cycle || (cmd.pick_emit && stat.done_last)) begin
        count_r <= '0;
        mask_r  <= '0;
      end
    end
  end

  // In-degree counters, one per vertex, updated in parallel.
  always_ff @(posedge clk) begin
    for (int j = 0; j < VERTEX_COUNT; j++) begin
      if (cmd.sort_init) begin
        deg_r[j] <= '0;
      end else if (cmd.deg_step && row_v[j] && mask_r[j]) begin
        deg_r[j] <= deg_r[j] + DEG_W'(1);
      end else if (pick_any && row_v[j] && mask_r[j] && deg_r[j] != '0) begin
        deg_r[j] <= deg_r[j] - DEG_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec_single || cmd.emit_empty || cmd.emit_cycle || cmd.pick_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_single || cmd.emit_empty || cmd.emit_cycle || cmd.pick_emit) begin
      out_r.status       <= ST_OK;
      out_r.edge_present <= 1'b0;
      out_r.vertex       <= '0;
      out_r.vertex_valid <= 1'b0;
      out_r.last         <= 1'b1;
      if (cmd.emit_cycle) begin
        out_r.status <= ST_CYCLE;
      end
      if (cmd.pick_emit) begin
        out_r.vertex       <= 6'(v);
        out_r.vertex_valid <= 1'b1;
        out_r.last         <= stat.done_last;
      end
      if (cmd.exec_single) begin
        unique case (item_r.command)
          CMD_ADD_EDGE: begin
            if (!f_ok || !t_ok || item_r.from_vertex == item_r.to_vertex) begin
              out_r.status <= ST_ERROR;
            end
          end
          CMD_REMOVE: begin
            if (!f_ok || !t_ok || !edge_bit) begin
              out_r.status <= ST_ERROR;
            end
          end
          CMD_QUERY: begin
            if (!f_ok || !t_ok) begin
              out_r.status <= ST_ERROR;
            end else begin
              out_r.edge_present <= edge_bit;
            end
          end
          CMD_ADD_MEMBER: begin
            if (!f_ok || full || dup) begin
              out_r.status <= ST_ERROR;
            end
          end
          default: begin
            out_r.status <= ST_ERROR;
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The membership mask always agrees with the member count.
  a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(mask_r) == int'(count_r))
    else $error("member mask and count disagree");

  // A result is only loaded when the result register can take it.
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_single || cmd.emit_empty || cmd.emit_cycle || cmd.pick_emit) |-> slot_free)
    else $error("result overwritten");

  // A picked vertex is unvisited with zero in-degree.
  a_pick: assert property (@(posedge clk) disable iff (!rst_n)
    pick_any |-> stat.candidate)
    else $error("invalid pick");

endmodule

FILE: hw/rtl/dest_ctrl.sv
// ----------------------------------------------------------------------------
// dest_ctrl
// Sequencer for single requests and the sort passes.
// ----------------------------------------------------------------------------
module dest_ctrl import dest_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DEG, S_SCAN, S_EMIT, S_CYC, S_RESTART
  } state_t;

  state_t state_r, state_nxt;
  // Low during the silent pass that checks for a cycle, high while emitting.
  logic   emit_pass_r, emit_pass_nxt;

  assign in_stall = state_r != S_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    emit_pass_nxt = emit_pass_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.is_sort) begin
          if (stat.slot_free) begin
            cmd.exec_single = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (!stat.count_zero) begin
          cmd.sort_init = 1'b1;
          emit_pass_nxt = 1'b0;
          state_nxt     = S_DEG;
        end else if (stat.slot_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DEG: begin
        cmd.deg_step = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.candidate) begin
          state_nxt = S_EMIT;
        end else if (stat.idx_last) begin
          state_nxt = S_CYC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!emit_pass_r) begin
          // The first pass only proves the members have no cycle.
          cmd.pick_mark = 1'b1;
          state_nxt     = stat.done_last ? S_RESTART : S_SCAN;
        end else if (stat.slot_free) begin
          cmd.pick_emit = 1'b1;
          state_nxt     = stat.done_last ? S_IDLE : S_SCAN;
        end
      end
      S_RESTART: begin
        cmd.sort_init = 1'b1;
        emit_pass_nxt = 1'b1;
        state_nxt     = S_DEG;
      end
      S_CYC: begin
        if (stat.slot_free) begin
          cmd.emit_cycle = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_pass_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emit_pass_r <= emit_pass_nxt;
    end
  end

  // An accepted request always moves into execution.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_EXEC)
    else $error("accepted request not executed");

  // Sort passes only run for a sort request.
  a_sort_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEG || state_r == S_SCAN) |-> stat.is_sort)
    else $error("sort pass without sort request");

  // The second pass starts only after the silent pass.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESTART) |-> !emit_pass_r)
    else $error("restart during emit pass");

endmodule

FILE: hw/rtl/dag_edge_store_topo_sort_top.sv
// ----------------------------------------------------------------------------
// dag_edge_store_topo_sort_top
// Directed edge store with member list and topological sort.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall; results leave on out_valid/out_stall.
// One request is handled at a time: in_stall is high from the cycle after
// acceptance until the request has placed its last result in the output
// register. Edge and member requests execute in S_EXEC, which waits while
// the output register holds an untaken result, and then load their result.
// A sort runs Kahn's algorithm twice over the n members: a silent pass that
// only checks for a cycle, then a pass that emits the order. Each pass first
// builds in-degrees by stepping through the member list, then for each
// picked vertex scans the member list from its start one entry a cycle and
// picks the first unvisited entry with zero in-degree.
// A cycle is reported after the silent pass, before any vertex is emitted.
// A stalled result holds in the output register; the sort pauses until it
// is taken. Reset clears the edge matrix, the member list and the result
// register at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dag_edge_store_topo_sort_top import dest_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  dest_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result register.
  dest_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
